// ===== rtl/tnt_pkg.sv =====
// ---------------------------------------------------------------------------
// tnt_pkg
// shared widths, codes and control word layout for the key number table
// ---------------------------------------------------------------------------
package tnt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int KEY_W       = 31;
   localparam int SLOT_W      = 7;
   localparam int STATUS_W    = 2;
   localparam int CFG_W       = 7;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int BIT_W       = $clog2(KEY_W);

   localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_SLOT  = 2'd2;

   typedef logic [2:0] dp_op_type;
   localparam dp_op_type DP_LOAD   = 3'd0;
   localparam dp_op_type DP_MOD    = 3'd1;
   localparam dp_op_type DP_SINIT  = 3'd2;
   localparam dp_op_type DP_SCAN   = 3'd3;
   localparam dp_op_type DP_FINISH = 3'd4;

   typedef logic [2:0] cond_type;
   localparam cond_type COND_NEVER     = 3'd0;
   localparam cond_type COND_ALWAYS    = 3'd1;
   localparam cond_type COND_NO_START  = 3'd2;
   localparam cond_type COND_MOD_MORE  = 3'd3;
   localparam cond_type COND_SCAN_MORE = 3'd4;

   typedef logic [2:0] step_type;

   typedef struct packed {
      dp_op_type op;
      cond_type  cond;
      step_type  target;
   } ctrl_word_type;

   typedef struct packed {
      dp_op_type op;
   } seq_ctrl_type;

   typedef struct packed {
      logic mod_more;
      logic scan_more;
   } dp_flags_type;

endpackage

// ===== rtl/tnt_seq.sv =====
// ---------------------------------------------------------------------------
// tnt_seq
// step counter and control store; one control word per step
// ---------------------------------------------------------------------------
module tnt_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  tnt_pkg::dp_flags_type flags,
   output tnt_pkg::seq_ctrl_type ctrl,
   output logic                  busy
);
   import tnt_pkg::*;

   localparam step_type STEP_IDLE   = 3'd0;
   localparam step_type STEP_MOD    = 3'd1;
   localparam step_type STEP_SINIT  = 3'd2;
   localparam step_type STEP_SCAN   = 3'd3;
   localparam step_type STEP_FINISH = 3'd4;

   step_type      pc_ff;
   step_type      pc_in;
   ctrl_word_type word;
   logic          take;

   // control store
   always_comb begin
      case (pc_ff)
         STEP_IDLE:   word = '{op: DP_LOAD,   cond: COND_NO_START,  target: STEP_IDLE};
         STEP_MOD:    word = '{op: DP_MOD,    cond: COND_MOD_MORE,  target: STEP_MOD};
         STEP_SINIT:  word = '{op: DP_SINIT,  cond: COND_NEVER,     target: STEP_IDLE};
         STEP_SCAN:   word = '{op: DP_SCAN,   cond: COND_SCAN_MORE, target: STEP_SCAN};
         STEP_FINISH: word = '{op: DP_FINISH, cond: COND_ALWAYS,    target: STEP_IDLE};
         default:     word = '{op: DP_LOAD,   cond: COND_ALWAYS,    target: STEP_IDLE};
      endcase
   end

   always_comb begin
      case (word.cond)
         COND_NEVER:     take = 1'b0;
         COND_ALWAYS:    take = 1'b1;
         COND_NO_START:  take = !start;
         COND_MOD_MORE:  take = flags.mod_more;
         COND_SCAN_MORE: take = flags.scan_more;
         default:        take = 1'b1;
      endcase
   end

   assign pc_in   = take ? word.target : pc_ff + 3'd1;
   assign ctrl.op = word.op;
   assign busy    = (pc_ff != STEP_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== rtl/tnt_datapath.sv =====
// ---------------------------------------------------------------------------
// tnt_datapath
// remainder unit, probe address, key table memory and result registers
// ---------------------------------------------------------------------------
module tnt_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          req_operation,
   input  logic [tnt_pkg::KEY_W-1:0]     req_key_number,
   input  logic [tnt_pkg::CFG_W-1:0]     table_size,
   input  tnt_pkg::seq_ctrl_type         ctrl,
   output tnt_pkg::dp_flags_type         flags,
   output logic                          rsp_valid,
   output logic [tnt_pkg::STATUS_W-1:0]  rsp_status,
   output logic [tnt_pkg::SLOT_W-1:0]    rsp_slot_index,
   output logic                          rsp_key_found
);
   import tnt_pkg::*;

   logic [KEY_W-1:0]     key_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] vld_ff;

   logic                 attach_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [CNT_W-1:0]     size_ff, size_in;
   logic [CNT_W-1:0]     rem_ff;
   logic [BIT_W-1:0]     bit_ff;
   logic [CNT_W:0]       trial;
   logic [CNT_W-1:0]     rem_in;

   logic [IDX_W-1:0]     ra_ff, ra_next;
   logic [CNT_W-1:0]     issue_cnt_ff;
   logic                 cmp_vld_ff;
   logic [IDX_W-1:0]     cmp_idx_ff;
   logic [KEY_W-1:0]     rdata_ff;
   logic                 rvld_ff;
   logic [CNT_W-1:0]     cmp_cnt_ff;
   logic [KEY_W-1:0]     entry;
   logic                 match, free, last_cmp;

   logic                 found_ff, hole_ff;
   logic [CNT_W-1:0]     slot_ff;

   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [SLOT_W-1:0]    slot_out_ff;
   logic                 found_out_ff;
   logic                 wr_en;

   // clamp of the size register
   always_comb begin
      if (table_size == '0) begin
         size_in = CNT_W'(1);
      end else if (table_size > CFG_W'(TABLE_DEPTH)) begin
         size_in = CNT_W'(TABLE_DEPTH);
      end else begin
         size_in = CNT_W'(table_size);
      end
   end

   // restoring remainder, one key bit a step
   assign trial  = {rem_ff, key_ff[bit_ff]};
   assign rem_in = (trial >= {1'b0, size_ff}) ? CNT_W'(trial - {1'b0, size_ff})
                                               : CNT_W'(trial);

   assign ra_next = ((CNT_W'(ra_ff) + CNT_W'(1)) == size_ff) ? '0 : ra_ff + IDX_W'(1);

   assign entry    = rvld_ff ? rdata_ff : '0;
   assign match    = cmp_vld_ff && (key_ff != '0) && (entry == key_ff);
   assign free     = cmp_vld_ff && (entry == '0);
   assign last_cmp = cmp_vld_ff && (cmp_cnt_ff == size_ff - CNT_W'(1));

   assign flags.mod_more  = (bit_ff != '0);
   assign flags.scan_more = !(match || last_cmp);

   always_comb begin
      wr_en = 1'b0;
      if (key_ff == '0) begin
         status_in = ST_MISMATCH;
      end else if (attach_ff) begin
         if (found_ff) begin
            status_in = ST_MISMATCH;
         end else if (!hole_ff) begin
            status_in = ST_NO_SLOT;
         end else begin
            status_in = ST_OK;
            wr_en     = (ctrl.op == DP_FINISH);
         end
      end else begin
         status_in = found_ff ? ST_OK : ST_MISMATCH;
      end
   end

   // key table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[slot_ff[IDX_W-1:0]] <= key_ff;
      end
      rdata_ff <= key_mem[ra_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[slot_ff[IDX_W-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (ctrl.op == DP_FINISH);
         case (ctrl.op)
            DP_SINIT: cmp_vld_ff <= 1'b0;
            DP_SCAN:  cmp_vld_ff <= (issue_cnt_ff < size_ff);
            default:  cmp_vld_ff <= 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (ctrl.op)
         DP_LOAD: begin
            if (start) begin
               attach_ff <= req_operation;
               key_ff    <= req_key_number;
               size_ff   <= size_in;
               rem_ff    <= '0;
               bit_ff    <= BIT_W'(KEY_W - 1);
            end
         end
         DP_MOD: begin
            rem_ff <= rem_in;
            bit_ff <= bit_ff - BIT_W'(1);
         end
         DP_SINIT: begin
            ra_ff        <= rem_ff[IDX_W-1:0];
            issue_cnt_ff <= '0;
            cmp_cnt_ff   <= '0;
            found_ff     <= 1'b0;
            hole_ff      <= 1'b0;
            slot_ff      <= size_ff;
         end
         DP_SCAN: begin
            rvld_ff      <= vld_ff[ra_ff];
            cmp_idx_ff   <= ra_ff;
            ra_ff        <= ra_next;
            issue_cnt_ff <= issue_cnt_ff + CNT_W'(1);
            if (cmp_vld_ff) begin
               cmp_cnt_ff <= cmp_cnt_ff + CNT_W'(1);
            end
            if (match) begin
               found_ff <= 1'b1;
               slot_ff  <= CNT_W'(cmp_idx_ff);
            end else if (free && !hole_ff) begin
               hole_ff <= 1'b1;
               slot_ff <= CNT_W'(cmp_idx_ff);
            end
         end
         DP_FINISH: begin
            status_ff    <= status_in;
            slot_out_ff  <= SLOT_W'(slot_ff);
            found_out_ff <= found_ff;
         end
         default: begin
            rem_ff <= rem_ff;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_slot_index = slot_out_ff;
   assign rsp_key_found  = found_out_ff;

endmodule

// ===== rtl/tie_number_table_find_or_attach.sv =====
// ---------------------------------------------------------------------------
// tie_number_table_find_or_attach
// linear probing key table: find a key or attach it into the first free slot
// ---------------------------------------------------------------------------
// steps: one remainder step per key bit, one setup step, one probe per cycle through
//   the single table read port with its registered read, one finish step
// throughput: one request at a time; busy drops in the cycle the result shows
// reset clears the control state and the table valid bits; table_size is 64
// results are shown for one cycle on rsp_valid and cannot be held off
// ---------------------------------------------------------------------------
module tie_number_table_find_or_attach (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_operation,
   input  logic [tnt_pkg::KEY_W-1:0]     req_key_number,
   output logic                          rsp_valid,
   output logic [tnt_pkg::STATUS_W-1:0]  rsp_status,
   output logic [tnt_pkg::SLOT_W-1:0]    rsp_slot_index,
   output logic                          rsp_key_found,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tnt_pkg::CFG_W-1:0]     csr_table_size
);
   import tnt_pkg::*;

   logic [CFG_W-1:0] table_size_ff;
   seq_ctrl_type     ctrl;
   dp_flags_type     flags;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         table_size_ff <= csr_table_size;
      end
   end

   tnt_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .flags (flags),
      .ctrl  (ctrl),
      .busy  (busy)
   );

   tnt_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_operation  (req_operation),
      .req_key_number (req_key_number),
      .table_size     (table_size_ff),
      .ctrl           (ctrl),
      .flags          (flags),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_slot_index (rsp_slot_index),
      .rsp_key_found  (rsp_key_found)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result beat longer than one cycle");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_found_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_key_found) |-> (rsp_status != ST_NO_SLOT))
      else $error("no free slot reported for a present key");

endmodule
